// ===== rtl/core/rms_norm_pkg.sv =====
`default_nettype none
package rms_norm_pkg;

    localparam int RowCapacity = 64;
    localparam int AddrWidth   = 6;
    localparam int CountWidth  = 7;
    localparam int SumWidth    = 37;
    localparam int EpsWidth    = 24;
    localparam int InvWidth    = 29;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] gain;
        logic               row_end;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] y_value;
        logic               last_out;
        logic               row_overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] gain;
    } store_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/rms_norm_store.sv =====
`default_nettype none
module rms_norm_store (
    input  wire                                   clk,
    input  wire                                   wr_en,
    input  wire [rms_norm_pkg::AddrWidth-1:0]     wr_addr,
    input  wire rms_norm_pkg::store_word_t        wr_data,
    input  wire                                   rd_en,
    input  wire [rms_norm_pkg::AddrWidth-1:0]     rd_addr,
    output rms_norm_pkg::store_word_t             rd_data
);
    import rms_norm_pkg::*;

    store_word_t mem [RowCapacity];

    // Write one element and register the read word; hold the word when not enabled
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rms_norm_invsqrt.sv =====
`default_nettype none
module rms_norm_invsqrt (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    input  wire [rms_norm_pkg::SumWidth-1:0]      square_sum,
    input  wire [rms_norm_pkg::CountWidth-1:0]    count,
    input  wire [rms_norm_pkg::EpsWidth-1:0]      epsilon,
    output logic                                  done,
    output logic [rms_norm_pkg::InvWidth-1:0]     inv
);
    import rms_norm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_ADD, S_DIV2, S_SQRT
    } state_t;

    state_t       state_reg, state_next;
    logic [56:0]  rem_reg, rem_next;
    logic [56:0]  quo_reg, quo_next;
    logic [56:0]  den_reg, den_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [57:0]  sq_reg, sq_next;
    logic [29:0]  root_reg, root_next;
    logic [57:0]  trial;
    logic [57:0]  strial;
    logic [57:0]  sq_shift;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        root_next  = root_reg;
        trial      = '0;
        sq_shift   = '0;
        strial     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // divide the sum by the count, restoring, one bit a cycle
                    rem_next  = '0;
                    quo_next  = {20'd0, square_sum};
                    den_next  = {50'd0, count};
                    cnt_next  = 6'd37;
                    state_next = (count == '0) ? S_ADD : S_DIV1;
                    if (count == '0)
                    begin
                        quo_next = '0;
                    end
                end
            end
            S_DIV1, S_DIV2:
            begin
                trial = {rem_reg, quo_reg[(state_reg == S_DIV1) ? 36 : 56]};
                if (trial >= {1'b0, den_reg})
                begin
                    trial = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[55:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[55:0], 1'b0};
                end
                rem_next = trial[56:0];
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    if (state_reg == S_DIV1)
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        // pad the radicand to an even bit count
                        sq_next   = {1'b0, quo_next};
                        rem_next  = '0;
                        root_next = '0;
                        cnt_next  = 6'd29;
                        state_next = S_SQRT;
                    end
                end
            end
            S_ADD:
            begin
                // add epsilon, clamp zero to one, then divide 2^56 by it
                den_next = {20'd0, quo_reg[36:0]} + {33'd0, epsilon};
                if (den_next == '0)
                begin
                    den_next = 57'd1;
                end
                rem_next   = '0;
                quo_next   = {1'b1, 56'd0};
                cnt_next   = 6'd57;
                state_next = S_DIV2;
            end
            S_SQRT:
            begin
                // two radicand bits a cycle into the root
                sq_shift = {rem_reg[55:0], sq_reg[57:56]};
                strial   = {26'd0, root_reg, 2'b01};
                if (sq_shift >= strial)
                begin
                    rem_next  = sq_shift[56:0] - strial[56:0];
                    root_next = {root_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_shift[56:0];
                    root_next = {root_reg[28:0], 1'b0};
                end
                sq_next  = {sq_reg[55:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == S_SQRT) && (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        sq_reg   <= sq_next;
        root_reg <= root_next;
    end

    assign inv = root_reg[InvWidth-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/rms_row_normalizer_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | x_value, gain, row_end
// out     | output    | out_valid/out_stall| y_value, last_out, row_overflow
// cfg     | input     | cfg_we             | epsilon (24 bits)
// An element is taken with in_valid in load mode; a non-final one keeps the input free.
// The final element starts a factor unit: a bit-serial divide of the sum by the count,
// an epsilon add, a divide of 2^56 by that and a bit-serial root loop.
// Emission reads the row store at one element a cycle plus a three-stage product pipe,
// both held while a valid result is stalled.
// Reset clears counts, sum, flags and the epsilon register (17); stores are not cleared.
// Out stall freezes the emit pipe; input is held off until the row is emitted.
module rms_row_normalizer_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire rms_norm_pkg::in_item_t   in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output rms_norm_pkg::out_item_t       out_data,
    input  wire                           cfg_we,
    input  wire [rms_norm_pkg::EpsWidth-1:0] cfg_data
);
    import rms_norm_pkg::*;

    typedef enum logic [1:0] {
        M_LOAD, M_CALC, M_EMIT
    } mode_t;

    mode_t                 mode_reg;
    logic [EpsWidth-1:0]   eps_reg;
    logic [SumWidth-1:0]   sum_reg;
    logic [CountWidth-1:0] fill_reg;
    logic                  drop_reg;
    logic [CountWidth-1:0] rd_reg;
    logic                  v1_reg, v2_reg, v3_reg;
    logic                  l1_reg, l2_reg, l3_reg;
    logic                  start_reg;
    logic signed [31:0]    xg_reg;
    logic [61:0]           prod_reg;
    logic                  neg_reg;
    logic                  advance;
    logic                  accept;
    logic                  stored;
    logic                  calc_done;
    logic [InvWidth-1:0]   inv;
    store_word_t           rd_word;
    store_word_t           wr_word;
    logic [31:0]           xg_mag;
    logic [61:0]           rounded;
    logic [31:0]           ax_sq;
    logic [15:0]           ax;
    logic signed [15:0]    y_sat;

    assign in_stall = (mode_reg != M_LOAD);
    assign accept   = in_valid && !in_stall;
    assign stored   = accept && (fill_reg < CountWidth'(RowCapacity));
    assign advance  = !(out_valid && out_stall);
    assign wr_word  = '{x_value: in_data.x_value, gain: in_data.gain};
    assign ax       = in_data.x_value[15] ? 16'(-in_data.x_value) : in_data.x_value;
    assign ax_sq    = ax * ax;

    rms_norm_store u_store (
        .clk     (clk),
        .wr_en   (stored),
        .wr_addr (fill_reg[AddrWidth-1:0]),
        .wr_data (wr_word),
        .rd_en   (advance),
        .rd_addr (rd_reg[AddrWidth-1:0]),
        .rd_data (rd_word)
    );

    rms_norm_invsqrt u_inv (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .square_sum (sum_reg),
        .count      (fill_reg),
        .epsilon    (eps_reg),
        .done       (calc_done),
        .inv        (inv)
    );

    // Round the scaled magnitude and saturate by sign
    assign xg_mag  = xg_reg[31] ? 32'(-xg_reg) : 32'(xg_reg);
    assign rounded = (prod_reg + 62'd536870912) >> 30;
    always_comb
    begin
        if (neg_reg)
        begin
            y_sat = (rounded > 62'd32768) ? 16'sh8000 : 16'(-rounded[15:0]);
        end
        else
        begin
            y_sat = (rounded > 62'd32767) ? 16'sh7fff : rounded[15:0];
        end
    end

    // Control: load, compute factor, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_LOAD;
            eps_reg   <= EpsWidth'(17);
            sum_reg   <= '0;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            rd_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept && in_data.row_end;
            if (cfg_we)
            begin
                eps_reg <= cfg_data;
            end
            case (mode_reg)
                M_LOAD:
                begin
                    if (stored)
                    begin
                        fill_reg <= fill_reg + CountWidth'(1);
                        sum_reg  <= sum_reg + SumWidth'(ax_sq);
                    end
                    else if (accept)
                    begin
                        drop_reg <= 1'b1;
                    end
                    if (accept && in_data.row_end)
                    begin
                        mode_reg <= M_CALC;
                    end
                end
                M_CALC:
                begin
                    if (calc_done)
                    begin
                        rd_reg   <= '0;
                        mode_reg <= M_EMIT;
                    end
                end
                M_EMIT:
                begin
                    if (advance)
                    begin
                        if (out_valid && out_data.last_out)
                        begin
                            // close the row after its final transaction
                            mode_reg  <= M_LOAD;
                            fill_reg  <= '0;
                            sum_reg   <= '0;
                            drop_reg  <= 1'b0;
                            v1_reg    <= 1'b0;
                            v2_reg    <= 1'b0;
                            v3_reg    <= 1'b0;
                            out_valid <= 1'b0;
                        end
                        else
                        begin
                            v1_reg    <= (rd_reg < fill_reg);
                            v2_reg    <= v1_reg;
                            v3_reg    <= v2_reg;
                            out_valid <= v3_reg;
                            if (rd_reg < fill_reg)
                            begin
                                rd_reg <= rd_reg + CountWidth'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    mode_reg <= M_LOAD;
                end
            endcase
        end
    end

    // Emit pipe payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            l1_reg   <= (rd_reg + CountWidth'(1) == fill_reg);
            xg_reg   <= rd_word.x_value * rd_word.gain;
            neg_reg  <= xg_reg[31];
            prod_reg <= 62'(xg_mag) * 62'(inv);
            l2_reg   <= l1_reg;
            l3_reg   <= l2_reg;
            out_data <= '{y_value: y_sat, last_out: l3_reg, row_overflow: drop_reg};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_reg == M_EMIT))
        else $error("result outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |=> (mode_reg == M_CALC))
        else $error("factor start out of order");
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CountWidth'(RowCapacity))
        else $error("fill count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== tb/sv/tb_rms_row_normalizer_unit.sv =====
`timescale 1ns / 1ps
module tb_rms_row_normalizer_unit;
    import rms_norm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_we;
    logic [EpsWidth-1:0] cfg_data;

    // predictor state
    logic [15:0] x_row [RowCapacity];
    logic [15:0] g_row [RowCapacity];
    logic [SumWidth-1:0] sq_acc;
    int unsigned n_stored;
    bit overflowed;
    logic [EpsWidth-1:0] eps_reg;

    out_item_t pending_y [$];
    int error_count;
    int unsigned cycle_count;
    bit run_done;
    bit drain_mode;

    rms_row_normalizer_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_rms_row_normalizer_unit failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_y(input logic signed [15:0] x,
                                            input logic signed [15:0] g,
                                            input logic [63:0] inv);
        logic [63:0] ax;
        logic [63:0] ag;
        logic [63:0] mag;
        bit neg;
        neg = (x < 0) != (g < 0);
        ax = x < 0 ? 64'(-int'(x)) : 64'(int'(x));
        ag = g < 0 ? 64'(-int'(g)) : 64'(int'(g));
        mag = (ax * ag * inv + (64'd1 << 29)) >> 30;
        if (neg)
        begin
            if (mag > 32768) mag = 32768;
            return 16'(-mag);
        end
        if (mag > 32767) mag = 32767;
        return mag[15:0];
    endfunction

    // advance the predictor by one accepted element
    task automatic predict_element(input in_item_t it);
        logic [63:0] ax;
        logic [63:0] v;
        logic [63:0] inv;
        out_item_t r;
        if (n_stored < RowCapacity)
        begin
            ax = it.x_value < 0 ? 64'(-int'(it.x_value)) : 64'(int'(it.x_value));
            x_row[n_stored] = it.x_value;
            g_row[n_stored] = it.gain;
            n_stored++;
            sq_acc = sq_acc + SumWidth'(ax * ax);
        end
        else
            overflowed = 1'b1;
        if (!it.row_end) return;
        v = (n_stored != 0 ? 64'(sq_acc) / n_stored : 0) + 64'(eps_reg);
        if (v == 0) v = 1;
        inv = int_sqrt((64'd1 << 56) / v);
        for (int k = 0; k < n_stored; k++)
        begin
            r.y_value = scale_y(x_row[k], g_row[k], inv);
            r.last_out = (k + 1 == n_stored);
            r.row_overflow = overflowed;
            pending_y.push_back(r);
        end
        sq_acc = 0;
        n_stored = 0;
        overflowed = 1'b0;
    endtask

    // check each result transaction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_y.size() == 0)
                report_mismatch("result with no expectation");
            else
            begin
                want = pending_y.pop_front();
                if (out_data.y_value !== want.y_value)
                    report_mismatch($sformatf("y_value got %0d want %0d",
                                              out_data.y_value, want.y_value));
                if (out_data.last_out !== want.last_out)
                    report_mismatch("last_out");
                if (out_data.row_overflow !== want.row_overflow)
                    report_mismatch("row_overflow");
            end
        end
    end

    // random receiver stall: wait a drawn number of cycles before each transaction
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (drain_mode)
                out_stall <= 1'b0;
            else
            begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                end
                out_stall <= 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
        end
    end

    task automatic send_element(input logic signed [15:0] x, input logic signed [15:0] g,
                                input bit last);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{x_value: x, gain: g, row_end: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_element('{x_value: x, gain: g, row_end: last});
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_y.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_epsilon(input logic [EpsWidth-1:0] e);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= e;
        @(negedge clk);
        cfg_we <= 1'b0;
        eps_reg = e;
    endtask

    task automatic send_row(input int len, input bit loud);
        logic signed [15:0] x;
        for (int i = 0; i < len; i++)
        begin
            x = loud ? 16'($urandom) : 16'($signed(16'($urandom_range(0, 8191))) - 4096);
            send_element(x, 16'($urandom), i == len - 1);
        end
    endtask

    task automatic test_field_extremes();
        send_element(16'sh7fff, 16'sh7fff, 0);
        send_element(-16'sh8000, -16'sh8000, 0);
        send_element(-16'sh8000, 16'sh7fff, 0);
        send_element(16'sh0000, 16'sh4000, 0);
        send_element(16'sh1000, -16'sh4000, 1);
        send_element(16'sh0001, 16'sh7fff, 1);
    endtask

    task automatic test_zero_row();
        write_epsilon(24'd0);
        send_element(16'sh0000, 16'sh4000, 0);
        send_element(16'sh0000, -16'sh8000, 1);
        // tiny values with epsilon zero take the largest factor
        send_element(16'sh0001, 16'sh7fff, 0);
        send_element(-16'sh0001, 16'sh7fff, 1);
    endtask

    task automatic test_capacity_overflow();
        write_epsilon(24'hffffff);
        send_row(RowCapacity, 1);
        for (int i = 0; i < RowCapacity + 3; i++)
            send_element(16'($urandom), 16'($urandom), i == RowCapacity + 2);
        write_epsilon(24'd17);
    endtask

    task automatic test_random_rows();
        int sent;
        sent = 0;
        while (sent < 110)
        begin
            int len;
            if ($urandom_range(0, 15) == 0) write_epsilon(24'($urandom));
            len = $urandom_range(0, 19) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 8);
            send_row(len, $urandom_range(0, 1));
            sent += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        drain_mode = 0;
        sq_acc = 0;
        n_stored = 0;
        overflowed = 0;
        eps_reg = 24'd17;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_zero_row();
        test_capacity_overflow();
        test_random_rows();

        drain_mode = 1;
        wait_drained();
        if (error_count == 0)
            $display("tb_rms_row_normalizer_unit passed");
        else
            $display("tb_rms_row_normalizer_unit failed");
        $finish;
    end

endmodule
